// ===== rtl/core/fvc_pkg.sv =====
// ----------------------------------------------------------------------------
// fvc_pkg
// Shared types and constants for the FLAC vorbis comment parser.
// ----------------------------------------------------------------------------
package fvc_pkg;

   typedef enum logic [3:0] {
      PH_MAGIC,
      PH_TYPE,
      PH_BLEN,
      PH_SKIP,
      PH_VLEN,
      PH_VSKIP,
      PH_COUNT,
      PH_CLEN,
      PH_CBODY
   } fvc_phase_type;

   typedef enum logic [1:0] {
      ROLE_OTHER,
      ROLE_NAME,
      ROLE_SEP,
      ROLE_VALUE
   } fvc_role_type;

   typedef enum logic [1:0] {
      ST_PARSING,
      ST_FINISHED,
      ST_BAD_MAGIC,
      ST_NO_SEP
   } fvc_status_type;

   localparam logic [7:0] FVC_MAGIC [4] = '{8'h66, 8'h4C, 8'h61, 8'h43};
   localparam logic [7:0] FVC_LAST_FLAG = 8'h80;
   localparam logic [6:0] FVC_TYPE_MASK = 7'h7F;
   localparam logic [6:0] FVC_TYPE_VORBIS = 7'h04;
   localparam logic [7:0] FVC_SEP_CHAR = 8'h3D;

   typedef struct packed {
      fvc_phase_type  phase;
      logic [1:0]     byte_position;
      logic [31:0]    bytes_remaining;
      logic [31:0]    comments_left;
      logic           final_block_seen;
      logic           separator_found;
      fvc_status_type sticky_status;
   } fvc_state_type;

   localparam fvc_state_type FVC_STATE_RESET = '{
      phase:            PH_MAGIC,
      byte_position:    2'd0,
      bytes_remaining:  32'd0,
      comments_left:    32'd0,
      final_block_seen: 1'b0,
      separator_found:  1'b0,
      sticky_status:    ST_PARSING
   };

   typedef struct packed {
      logic [7:0]     echo_byte;
      fvc_role_type   role;
      logic           comment_end;
      fvc_status_type status;
   } fvc_result_type;

endpackage

// ===== rtl/core/fvc_stream_if.sv =====
// ----------------------------------------------------------------------------
// fvc_stream_if
// Valid/ready channels: byte requests in, tagged byte responses out.
// ----------------------------------------------------------------------------
interface fvc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       restart;

   modport source (output valid, output data_byte, output restart, input ready);
   modport sink   (input valid, input data_byte, input restart, output ready);
endinterface

interface fvc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] echo_byte;
   logic [1:0] role;
   logic       comment_end;
   logic [1:0] status;

   modport source (output valid, output echo_byte, output role, output comment_end,
                   output status, input ready);
   modport sink   (input valid, input echo_byte, input role, input comment_end,
                   input status, output ready);
endinterface

// ===== rtl/core/fvc_step.sv =====
// ----------------------------------------------------------------------------
// fvc_step
// One byte of parser work: next state and tagged result from current state.
// ----------------------------------------------------------------------------
module fvc_step
   import fvc_pkg::*;
(
   input  fvc_state_type  cur_state,
   input  logic [7:0]     data_byte,
   input  logic           restart,
   output fvc_state_type  next_state,
   output fvc_result_type result
);

   fvc_state_type s;
   fvc_state_type n;
   fvc_role_type  role;
   logic          cend;
   logic [4:0]    shamt;
   logic [31:0]   le_byte;
   logic [31:0]   rem_dec;
   logic [31:0]   cnt_dec;
   logic [23:0]   blen;

   // operands shared by the next-state and output logic
   always_comb begin
      s       = restart ? FVC_STATE_RESET : cur_state;
      shamt   = {s.byte_position, 3'b000};
      le_byte = 32'(data_byte) << shamt;
      rem_dec = s.bytes_remaining - 32'd1;
      cnt_dec = s.comments_left - 32'd1;
      blen    = {s.bytes_remaining[15:0], data_byte};
   end

   // next state
   always_comb begin
      n = s;

      if (s.sticky_status == ST_PARSING) begin
         case (s.phase)
            PH_MAGIC: begin
               if (data_byte != FVC_MAGIC[s.byte_position]) begin
                  n.sticky_status = ST_BAD_MAGIC;
               end else if (s.byte_position == 2'd3) begin
                  n.byte_position = 2'd0;
                  n.phase         = PH_TYPE;
               end else begin
                  n.byte_position = s.byte_position + 2'd1;
               end
            end
            PH_TYPE: begin
               n.final_block_seen = (data_byte & FVC_LAST_FLAG) != 8'd0;
               // separator flag doubles as "this is the vorbis block"
               n.separator_found  = (data_byte[6:0] & FVC_TYPE_MASK) == FVC_TYPE_VORBIS;
               n.bytes_remaining  = 32'd0;
               n.byte_position    = 2'd0;
               n.phase            = PH_BLEN;
            end
            PH_BLEN: begin
               n.bytes_remaining = 32'(blen);
               if (s.byte_position == 2'd2) begin
                  n.byte_position = 2'd0;
                  if (s.separator_found) begin
                     n.separator_found = 1'b0;
                     n.bytes_remaining = 32'd0;
                     n.phase           = PH_VLEN;
                  end else if (blen == 24'd0) begin
                     if (s.final_block_seen) n.sticky_status = ST_FINISHED;
                     else n.phase = PH_TYPE;
                  end else begin
                     n.phase = PH_SKIP;
                  end
               end else begin
                  n.byte_position = s.byte_position + 2'd1;
               end
            end
            PH_SKIP: begin
               n.bytes_remaining = rem_dec;
               if (rem_dec == 32'd0) begin
                  if (s.final_block_seen) n.sticky_status = ST_FINISHED;
                  else n.phase = PH_TYPE;
               end
            end
            PH_VLEN: begin
               n.bytes_remaining = s.bytes_remaining | le_byte;
               if (s.byte_position == 2'd3) begin
                  n.byte_position = 2'd0;
                  if ((s.bytes_remaining | le_byte) == 32'd0) begin
                     n.comments_left = 32'd0;
                     n.phase         = PH_COUNT;
                  end else begin
                     n.phase = PH_VSKIP;
                  end
               end else begin
                  n.byte_position = s.byte_position + 2'd1;
               end
            end
            PH_VSKIP: begin
               n.bytes_remaining = rem_dec;
               if (rem_dec == 32'd0) begin
                  n.comments_left = 32'd0;
                  n.byte_position = 2'd0;
                  n.phase         = PH_COUNT;
               end
            end
            PH_COUNT: begin
               n.comments_left = s.comments_left | le_byte;
               if (s.byte_position == 2'd3) begin
                  n.byte_position   = 2'd0;
                  n.bytes_remaining = 32'd0;
                  if ((s.comments_left | le_byte) == 32'd0) begin
                     if (s.final_block_seen) n.sticky_status = ST_FINISHED;
                     else n.phase = PH_TYPE;
                  end else begin
                     n.phase = PH_CLEN;
                  end
               end else begin
                  n.byte_position = s.byte_position + 2'd1;
               end
            end
            PH_CLEN: begin
               n.bytes_remaining = s.bytes_remaining | le_byte;
               if (s.byte_position == 2'd3) begin
                  n.byte_position = 2'd0;
                  if ((s.bytes_remaining | le_byte) == 32'd0) begin
                     n.sticky_status = ST_NO_SEP;
                  end else begin
                     n.separator_found = 1'b0;
                     n.phase           = PH_CBODY;
                  end
               end else begin
                  n.byte_position = s.byte_position + 2'd1;
               end
            end
            PH_CBODY: begin
               if (!s.separator_found && data_byte == FVC_SEP_CHAR) begin
                  n.separator_found = 1'b1;
               end
               n.bytes_remaining = rem_dec;
               if (rem_dec == 32'd0) begin
                  if (!n.separator_found) begin
                     n.sticky_status = ST_NO_SEP;
                  end else begin
                     n.comments_left = cnt_dec;
                     if (cnt_dec == 32'd0) begin
                        if (s.final_block_seen) n.sticky_status = ST_FINISHED;
                        else n.phase = PH_TYPE;
                     end else begin
                        n.byte_position = 2'd0;
                        n.phase         = PH_CLEN;
                     end
                  end
               end
            end
            default: begin
               n.phase         = PH_MAGIC;
               n.byte_position = 2'd0;
            end
         endcase
      end

      next_state = n;
   end

   // byte tag and status
   always_comb begin
      role = ROLE_OTHER;
      cend = 1'b0;
      if (s.sticky_status == ST_PARSING && s.phase == PH_CBODY) begin
         if (s.separator_found) begin
            role = ROLE_VALUE;
         end else if (data_byte == FVC_SEP_CHAR) begin
            role = ROLE_SEP;
         end else begin
            role = ROLE_NAME;
         end
         cend = (rem_dec == 32'd0);
      end

      result.echo_byte   = data_byte;
      result.role        = role;
      result.comment_end = cend;
      result.status      = n.sticky_status;
   end

endmodule

// ===== rtl/core/flac_vorbis_comment_parser_unit.sv =====
// ----------------------------------------------------------------------------
// flac_vorbis_comment_parser_unit
// FLAC metadata walker that tags the bytes of each vorbis comment.
// ----------------------------------------------------------------------------
// Usage:
//   req_if carries one file byte per transfer plus a restart flag that marks
//   the first byte of a new file (parser state is cleared before that byte).
//   rsp_if returns one result per request, in order: the echoed byte, its
//   role (header/skipped, name, first '=', value), an end-of-comment flag,
//   and the sticky status (parsing, finished, bad magic, missing separator).
// Timing:
//   Two register stages: an input register and a result register, with the
//   parse step (one state update per byte) between them. Each request passes
//   both registers; throughput is 1 byte per cycle unless the output stalls.
//   The parser state advances only when a byte moves into the result stage.
// Reset:
//   Synchronous, active high. Both stages empty, parser expects the first
//   magic byte, status parsing.
// Stall:
//   When rsp_if.ready is low the result holds; the input register still takes
//   one more byte, then req_if.ready drops until the result is taken.
// ----------------------------------------------------------------------------
module flac_vorbis_comment_parser_unit
   import fvc_pkg::*;
(
   input  logic  clock,
   input  logic  reset,
   fvc_req_if.sink   req_if,
   fvc_rsp_if.source rsp_if
);

   // input stage
   logic           in_valid_ff;
   logic           in_valid_in;
   logic [7:0]     in_byte_ff;
   logic           in_restart_ff;

   // result stage
   logic           out_valid_ff;
   logic           out_valid_in;
   fvc_result_type out_ff;

   // parser state
   fvc_state_type  state_ff;
   fvc_state_type  state_in;

   fvc_state_type  step_next;
   fvc_result_type step_result;

   logic           req_xfer;
   logic           out_free;
   logic           move;

   fvc_step u_step (
      .cur_state  (state_ff),
      .data_byte  (in_byte_ff),
      .restart    (in_restart_ff),
      .next_state (step_next),
      .result     (step_result)
   );

   // result stage can load when empty or being drained this cycle
   assign out_free = !out_valid_ff || rsp_if.ready;
   assign move     = in_valid_ff && out_free;
   assign req_xfer = req_if.valid && req_if.ready;

   assign req_if.ready = !in_valid_ff || move;

   always_comb begin
      in_valid_in  = req_xfer ? 1'b1 : (move ? 1'b0 : in_valid_ff);
      out_valid_in = move ? 1'b1 : (rsp_if.ready ? 1'b0 : out_valid_ff);
      state_in     = move ? step_next : state_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= FVC_STATE_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_byte_ff    <= req_if.data_byte;
         in_restart_ff <= req_if.restart;
      end
      if (move) begin
         out_ff <= step_result;
      end
   end

   assign rsp_if.valid       = out_valid_ff;
   assign rsp_if.echo_byte   = out_ff.echo_byte;
   assign rsp_if.role        = out_ff.role;
   assign rsp_if.comment_end = out_ff.comment_end;
   assign rsp_if.status      = out_ff.status;

endmodule

// ===== rtl/core/fvc_checker.sv =====
// ----------------------------------------------------------------------------
// fvc_checker
// Port-level assertions for the parser unit, bound to the top level.
// ----------------------------------------------------------------------------
module fvc_checker
   import fvc_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_echo_byte,
   input logic [1:0] rsp_role,
   input logic       rsp_comment_end,
   input logic [1:0] rsp_status
);

   // nothing comes out right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_echo_byte)
         && $stable(rsp_role) && $stable(rsp_comment_end) && $stable(rsp_status))
      else $error("stalled response changed");

   // a draining output never blocks the input side
   a_no_bubble: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("request stalled while response side ready");

   // bad magic only arises in the file header
   a_magic_role: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_BAD_MAGIC |-> rsp_role == ROLE_OTHER && !rsp_comment_end)
      else $error("bad magic on a comment byte");

   // a comment that closes cleanly has seen its separator
   a_end_has_sep: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_comment_end && rsp_status != ST_NO_SEP
         |-> rsp_role == ROLE_SEP || rsp_role == ROLE_VALUE)
      else $error("comment ended without separator");

endmodule

bind flac_vorbis_comment_parser_unit fvc_checker u_fvc_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_if.ready),
   .rsp_valid       (rsp_if.valid),
   .rsp_ready       (rsp_if.ready),
   .rsp_echo_byte   (rsp_if.echo_byte),
   .rsp_role        (rsp_if.role),
   .rsp_comment_end (rsp_if.comment_end),
   .rsp_status      (rsp_if.status)
);
